/* hdl/assert_macros.svh */
// assertion macros used by the point query unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, quiet while reset is asserted
`define AQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// clocked check that also holds during reset
`define AQ_ASSERT_NORST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: check failed");

`else

`define AQ_ASSERT(lbl, clk, rst_n, prop)
`define AQ_ASSERT_NORST(lbl, clk, prop)

`endif

`endif

/* hdl/aabb_pkg.sv */
package aabb_pkg;

	// default coordinate width, signed fixed point
	localparam int COORD_WIDTH = 32;

	// configuration index width
	localparam int CFG_INDEX_WIDTH = 3;

	// configuration register map
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_reg_t;

endpackage

/* hdl/aabb_front.sv */
module aabb_front #(
	parameter int W = aabb_pkg::COORD_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0][W-1:0]     point,
	input  logic [2:0][W-1:0]     box_lo,
	input  logic [2:0][W-1:0]     box_hi,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  in_box,
	output logic [2:0][W-1:0]     closest,
	output logic [W-1:0]          gap,
	output logic [2*W+1:0]        sumsq
);

	localparam int LB    = (W + 1) / 2;
	localparam int HB    = W - LB;
	localparam int SQ_W  = 2 * W;
	localparam int SUM_W = 2 * W + 2;

	// stage valids and ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: clamp, containment per axis, face gaps
	logic [2:0][W-1:0] c_d1, g0_d1, g1_d1;
	logic [2:0]        in_d1;

	always_comb begin
		logic signed [W-1:0] p, lo, hi;
		logic below, above, inv;
		logic [W:0] g0w, g1w;
		for (int a = 0; a < 3; a++) begin
			p     = $signed(point[a]);
			lo    = $signed(box_lo[a]);
			hi    = $signed(box_hi[a]);
			below = p < lo;
			above = p > hi;
			inv   = lo > hi;
			if (below) begin
				c_d1[a] = inv ? box_hi[a] : box_lo[a];
			end else if (above) begin
				c_d1[a] = box_hi[a];
			end else begin
				c_d1[a] = point[a];
			end
			in_d1[a] = !below && !above;
			g0w      = {point[a][W-1], point[a]} - {box_lo[a][W-1], box_lo[a]};
			g1w      = {box_hi[a][W-1], box_hi[a]} - {point[a][W-1], point[a]};
			g0_d1[a] = g0w[W-1:0];
			g1_d1[a] = g1w[W-1:0];
		end
	end

	logic [2:0][W-1:0] c_s1, p_s1, g0_s1, g1_s1;
	logic [2:0]        in_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			c_s1  <= c_d1;
			p_s1  <= point;
			g0_s1 <= g0_d1;
			g1_s1 <= g1_d1;
			in_s1 <= in_d1;
		end
	end

	// stage 2: distance per axis, nearer face per axis
	logic [2:0][W-1:0] d_d2, gm_d2;

	always_comb begin
		logic [W:0] df;
		logic [W:0] mag;
		for (int a = 0; a < 3; a++) begin
			df       = {c_s1[a][W-1], c_s1[a]} - {p_s1[a][W-1], p_s1[a]};
			mag      = df[W] ? (~df + 1'b1) : df;
			d_d2[a]  = mag[W-1:0];
			gm_d2[a] = (g0_s1[a] < g1_s1[a]) ? g0_s1[a] : g1_s1[a];
		end
	end

	logic [2:0][W-1:0] c_s2, d_s2, gm_s2;
	logic              in_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			c_s2  <= c_s1;
			d_s2  <= d_d2;
			gm_s2 <= gm_d2;
			in_s2 <= &in_s1;
		end
	end

	// stage 3: half-width partial products, least face gap
	logic [2:0][2*LB-1:0] pll_d3;
	logic [2:0][W-1:0]    plh_d3;
	logic [2:0][2*HB-1:0] phh_d3;
	logic [W-1:0]         gap_d3;

	always_comb begin
		logic [LB-1:0] dl;
		logic [HB-1:0] dh;
		logic [W-1:0]  gxy;
		for (int a = 0; a < 3; a++) begin
			dl        = d_s2[a][LB-1:0];
			dh        = d_s2[a][W-1:LB];
			pll_d3[a] = dl * dl;
			plh_d3[a] = W'(dl) * W'(dh);
			phh_d3[a] = (2*HB)'(dh) * (2*HB)'(dh);
		end
		gxy    = (gm_s2[1] < gm_s2[0]) ? gm_s2[1] : gm_s2[0];
		gap_d3 = (gm_s2[2] < gxy) ? gm_s2[2] : gxy;
	end

	logic [2:0][2*LB-1:0] pll_s3;
	logic [2:0][W-1:0]    plh_s3;
	logic [2:0][2*HB-1:0] phh_s3;
	logic [2:0][W-1:0]    c_s3;
	logic [W-1:0]         gap_s3;
	logic                 in_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			pll_s3 <= pll_d3;
			plh_s3 <= plh_d3;
			phh_s3 <= phh_d3;
			c_s3   <= c_s2;
			gap_s3 <= gap_d3;
			in_s3  <= in_s2;
		end
	end

	// stage 4: assemble squares
	logic [2:0][SQ_W-1:0] sq_d4;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sq_d4[a] = (SQ_W'(phh_s3[a]) << (2 * LB))
				+ (SQ_W'(plh_s3[a]) << (LB + 1))
				+ SQ_W'(pll_s3[a]);
		end
	end

	logic [2:0][SQ_W-1:0] sq_s4;
	logic [2:0][W-1:0]    c_s4;
	logic [W-1:0]         gap_s4;
	logic                 in_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			sq_s4  <= sq_d4;
			c_s4   <= c_s3;
			gap_s4 <= gap_s3;
			in_s4  <= in_s3;
		end
	end

	// stage 5: sum of squares
	logic [SUM_W-1:0]  sum_s5;
	logic [2:0][W-1:0] c_s5;
	logic [W-1:0]      gap_s5;
	logic              in_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			sum_s5 <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			c_s5   <= c_s4;
			gap_s5 <= gap_s4;
			in_s5  <= in_s4;
		end
	end

	assign out_valid = v_s5;
	assign in_box    = in_s5;
	assign closest   = c_s5;
	assign gap       = gap_s5;
	assign sumsq     = sum_s5;

endmodule

/* hdl/aabb_sqrt_cell.sv */
module aabb_sqrt_cell #(
	parameter int W = aabb_pkg::COORD_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2*W+1:0]        in_rad,
	input  logic [W+2:0]          in_rem,
	input  logic [W:0]            in_root,
	input  logic                  in_inside,
	input  logic [2:0][W-1:0]     in_closest,
	input  logic [W-1:0]          in_gap,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2*W+1:0]        out_rad,
	output logic [W+2:0]          out_rem,
	output logic [W:0]            out_root,
	output logic                  out_inside,
	output logic [2:0][W-1:0]     out_closest,
	output logic [W-1:0]          out_gap
);

	localparam int N  = W + 1;
	localparam int RW = N + 2;
	localparam int SW = 2 * N;

	logic          valid_q;
	logic [SW-1:0] rad_q;
	logic [RW-1:0] rem_q;
	logic [N-1:0]  root_q;
	logic          inside_q;
	logic [2:0][W-1:0] closest_q;
	logic [W-1:0]  gap_q;

	assign in_ready = !valid_q || out_ready;

	// one root bit: bring down two radicand bits, try 4r+1
	logic [RW-1:0] x, trial, rem_n;
	logic          ge;

	always_comb begin
		x     = {in_rem[RW-3:0], in_rad[SW-1 -: 2]};
		trial = {in_root, 2'b01};
		ge    = x >= trial;
		rem_n = ge ? (x - trial) : x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rad_q     <= {in_rad[SW-3:0], 2'b00};
			rem_q     <= rem_n;
			root_q    <= {in_root[N-2:0], ge};
			inside_q  <= in_inside;
			closest_q <= in_closest;
			gap_q     <= in_gap;
		end
	end

	assign out_valid   = valid_q;
	assign out_rad     = rad_q;
	assign out_rem     = rem_q;
	assign out_root    = root_q;
	assign out_inside  = inside_q;
	assign out_closest = closest_q;
	assign out_gap     = gap_q;

endmodule

/* hdl/aabb_point_query_unit.sv */
// point query against an axis-aligned box held in six configuration registers
// config channel: cfg_valid/cfg_ready with cfg_index (0..2 min x/y/z, 3..5 max
//   x/y/z) and cfg_data; cfg_ready is always high, other indexes are dropped
// input channel: in_valid/in_ready, one point word (point_x/y/z) per transfer
// output channel: out_valid/out_ready, one result word per point: inside flag,
//   clamped point, floored euclidean distance and boundary distance
// pipeline: five front stages (clamp, difference, partial products, squares,
//   sum), one square root cell per root bit (COORD_WIDTH + 1 cells), one
//   output register
// throughput: one point per cycle unless stalled; every stage and cell takes a
//   new word each cycle, the root comes from a chain of cells one bit deep each
// stall: each stage holds its word while the next is full, so a stalled
//   receiver fills the chain; in_ready drops only once every stage is occupied
// reset: all stage valids clear and the box registers return to zero
`include "assert_macros.svh"

module aabb_point_query_unit #(
	parameter int COORD_WIDTH = aabb_pkg::COORD_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [aabb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]              cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [COORD_WIDTH-1:0]              point_x,
	input  logic [COORD_WIDTH-1:0]              point_y,
	input  logic [COORD_WIDTH-1:0]              point_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                inside_res,
	output logic [COORD_WIDTH-1:0]              closest_x,
	output logic [COORD_WIDTH-1:0]              closest_y,
	output logic [COORD_WIDTH-1:0]              closest_z,
	output logic [COORD_WIDTH:0]                outside_distance,
	output logic [COORD_WIDTH:0]                boundary_distance
);

	import aabb_pkg::*;

	localparam int W     = COORD_WIDTH;
	localparam int N     = W + 1;
	localparam int RW    = N + 2;
	localparam int SUM_W = 2 * N;

	// box registers
	logic [2:0][W-1:0] box_lo_q, box_hi_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_lo_q <= '0;
			box_hi_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_X: box_lo_q[0] <= cfg_data;
				REG_MIN_Y: box_lo_q[1] <= cfg_data;
				REG_MIN_Z: box_lo_q[2] <= cfg_data;
				REG_MAX_X: box_hi_q[0] <= cfg_data;
				REG_MAX_Y: box_hi_q[1] <= cfg_data;
				REG_MAX_Z: box_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// taps between front and square root cells
	logic                 vld_c    [0:N];
	logic                 rdy_c    [0:N];
	logic [SUM_W-1:0]     rad_c    [0:N];
	logic [RW-1:0]        rem_c    [0:N];
	logic [N-1:0]         root_c   [0:N];
	logic                 ins_c    [0:N];
	logic [2:0][W-1:0]    clo_c    [0:N];
	logic [W-1:0]         gap_c    [0:N];

	aabb_front #(
		.W (W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.point     ({point_z, point_y, point_x}),
		.box_lo    (box_lo_q),
		.box_hi    (box_hi_q),
		.out_valid (vld_c[0]),
		.out_ready (rdy_c[0]),
		.in_box    (ins_c[0]),
		.closest   (clo_c[0]),
		.gap       (gap_c[0]),
		.sumsq     (rad_c[0])
	);

	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	// one cell per root bit, most significant first
	for (genvar k = 0; k < N; k++) begin : g_cell
		aabb_sqrt_cell #(
			.W (W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.in_valid    (vld_c[k]),
			.in_ready    (rdy_c[k]),
			.in_rad      (rad_c[k]),
			.in_rem      (rem_c[k]),
			.in_root     (root_c[k]),
			.in_inside   (ins_c[k]),
			.in_closest  (clo_c[k]),
			.in_gap      (gap_c[k]),
			.out_valid   (vld_c[k+1]),
			.out_ready   (rdy_c[k+1]),
			.out_rad     (rad_c[k+1]),
			.out_rem     (rem_c[k+1]),
			.out_root    (root_c[k+1]),
			.out_inside  (ins_c[k+1]),
			.out_closest (clo_c[k+1]),
			.out_gap     (gap_c[k+1])
		);
	end

	// output register, boundary distance picked here
	logic              out_valid_q;
	logic              inside_q;
	logic [2:0][W-1:0] closest_q;
	logic [N-1:0]      dist_q;
	logic [N-1:0]      bound_q;

	assign rdy_c[N] = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_c[N]) begin
			out_valid_q <= vld_c[N];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_c[N] && vld_c[N]) begin
			inside_q  <= ins_c[N];
			closest_q <= clo_c[N];
			dist_q    <= root_c[N];
			bound_q   <= ins_c[N] ? {1'b0, gap_c[N]} : root_c[N];
		end
	end

	assign out_valid         = out_valid_q;
	assign inside_res        = inside_q;
	assign closest_x         = closest_q[0];
	assign closest_y         = closest_q[1];
	assign closest_z         = closest_q[2];
	assign outside_distance  = dist_q;
	assign boundary_distance = bound_q;

	// a point in the box is at distance zero from it
	`AQ_ASSERT(a_inside_zero_dist, clk, arst_n, out_valid && inside_res |-> outside_distance == '0)
	// outside the box both distances agree
	`AQ_ASSERT(a_outside_same_dist, clk, arst_n, out_valid && !inside_res |-> boundary_distance == outside_distance)
	// input back-pressure only comes from a stalled receiver
	`AQ_ASSERT_NORST(a_stall_from_output, clk, !in_ready |-> out_valid && !out_ready)

endmodule
